/* hdl/distance_constraint_relax_top_assert.svh */
// assertion macros used by the top-level design file
`ifndef DISTANCE_CONSTRAINT_RELAX_TOP_ASSERT_SVH
`define DISTANCE_CONSTRAINT_RELAX_TOP_ASSERT_SVH

// same-cycle implication
`define DCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define DCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/dcr_pkg.sv */
`default_nettype none
package dcr_pkg;

  // length used when both points coincide
  localparam int unsigned TINY_LEN = 7;

  typedef struct packed {
    logic valid;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* hdl/dcr_mul_cell.sv */
`default_nettype none
module dcr_mul_cell
  import dcr_pkg::*;
#(
  parameter int AW  = 33,
  parameter int MW  = 33,
  parameter int PW  = 66,
  parameter int SW  = 132,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  cell_ctl_t     in_ctl,
  input  logic [SW-1:0] in_side,
  input  logic [AW-1:0] in_a0,
  input  logic [AW-1:0] in_a1,
  input  logic [MW-1:0] in_m0,
  input  logic [MW-1:0] in_m1,
  input  logic [PW-1:0] in_acc0,
  input  logic [PW-1:0] in_acc1,
  output cell_ctl_t     out_ctl,
  output logic [SW-1:0] out_side,
  output logic [AW-1:0] out_a0,
  output logic [AW-1:0] out_a1,
  output logic [MW-1:0] out_m0,
  output logic [MW-1:0] out_m1,
  output logic [PW-1:0] out_acc0,
  output logic [PW-1:0] out_acc1
);

  logic [PW-1:0] pp0;
  logic [PW-1:0] pp1;

  assign pp0 = in_m0[BIT] ? (PW'(in_a0) << BIT) : '0;
  assign pp1 = in_m1[BIT] ? (PW'(in_a1) << BIT) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_a0   <= in_a0;
      out_a1   <= in_a1;
      out_m0   <= in_m0;
      out_m1   <= in_m1;
      out_acc0 <= in_acc0 + pp0;
      out_acc1 <= in_acc1 + pp1;
    end
  end

endmodule
`default_nettype wire

/* hdl/dcr_sqrt_cell.sv */
`default_nettype none
module dcr_sqrt_cell
  import dcr_pkg::*;
#(
  parameter int RW  = 33,
  parameter int SW  = 198,
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cell_ctl_t       in_ctl,
  input  logic [SW-1:0]   in_side,
  input  logic [2*RW-1:0] in_rem,
  input  logic [RW-1:0]   in_root,
  output cell_ctl_t       out_ctl,
  output logic [SW-1:0]   out_side,
  output logic [2*RW-1:0] out_rem,
  output logic [RW-1:0]   out_root
);

  localparam int RMW = 2 * RW;

  logic [RMW-1:0] trial;
  logic           ge;

  // (root + 2^k)^2 - root^2
  assign trial = (RMW'(in_root) << (BIT + 1)) | (RMW'(1) << (2 * BIT));
  assign ge    = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= ge ? in_rem - trial : in_rem;
      out_root <= ge ? (in_root | (RW'(1) << BIT)) : in_root;
    end
  end

endmodule
`default_nettype wire

/* hdl/dcr_div_cell.sv */
`default_nettype none
module dcr_div_cell
  import dcr_pkg::*;
#(
  parameter int NW  = 68,
  parameter int DW  = 35,
  parameter int QW  = 33,
  parameter int SW  = 132,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  cell_ctl_t     in_ctl,
  input  logic [SW-1:0] in_side,
  input  logic [DW-1:0] in_d,
  input  logic [NW-1:0] in_rem0,
  input  logic [NW-1:0] in_rem1,
  input  logic [QW-1:0] in_q0,
  input  logic [QW-1:0] in_q1,
  output cell_ctl_t     out_ctl,
  output logic [SW-1:0] out_side,
  output logic [DW-1:0] out_d,
  output logic [NW-1:0] out_rem0,
  output logic [NW-1:0] out_rem1,
  output logic [QW-1:0] out_q0,
  output logic [QW-1:0] out_q1
);

  logic [NW-1:0] trial;
  logic          ge0;
  logic          ge1;

  assign trial = NW'(in_d) << BIT;
  assign ge0   = in_rem0 >= trial;
  assign ge1   = in_rem1 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_d    <= in_d;
      out_rem0 <= ge0 ? in_rem0 - trial : in_rem0;
      out_rem1 <= ge1 ? in_rem1 - trial : in_rem1;
      out_q0   <= ge0 ? (in_q0 | (QW'(1) << BIT)) : in_q0;
      out_q1   <= ge1 ? (in_q1 | (QW'(1) << BIT)) : in_q1;
    end
  end

endmodule
`default_nettype wire

/* hdl/distance_constraint_relax_top.sv */
// throughput: one beat per cycle, set by the bit cells of the squaring, root,
// product and quotient chains, one result bit per cell
// the chain stalls only while the output skid register is full
// reset (rst, synchronous) clears the valid bits of every stage and the output side
`default_nettype none
`include "distance_constraint_relax_top_assert.svh"
module distance_constraint_relax_top
  import dcr_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] first_x,
  input  logic [COORD_WIDTH-1:0] first_y,
  input  logic [COORD_WIDTH-1:0] second_x,
  input  logic [COORD_WIDTH-1:0] second_y,
  input  logic [COORD_WIDTH-2:0] rest_length,
  input  logic                   first_static,
  input  logic                   second_static,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] new_first_x,
  output logic [COORD_WIDTH-1:0] new_first_y,
  output logic [COORD_WIDTH-1:0] new_second_x,
  output logic [COORD_WIDTH-1:0] new_second_y
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = W + 1;
  localparam int SQW = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int QW  = W + 1;
  localparam int NW  = 2 * W + 4;
  localparam int DNW = W + 3;
  localparam int SA  = 4 * W + 4;
  localparam int SB  = SA + 2 * AW;
  localparam int SC  = SA + RW;
  localparam int RES = 4 * W;

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  // front stage: deltas
  logic          d_sx;
  logic          d_sy;
  logic [W:0]    dx;
  logic [W:0]    dy;
  cell_ctl_t     f_ctl;
  logic [SA-1:0] f_side;
  logic [AW-1:0] f_ax;
  logic [AW-1:0] f_ay;

  assign dx   = {second_x[W-1], second_x} - {first_x[W-1], first_x};
  assign dy   = {second_y[W-1], second_y} - {first_y[W-1], first_y};
  assign d_sx = dx[W];
  assign d_sy = dy[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else if (en) begin
      f_ctl.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side <= {first_x, first_y, second_x, second_y, first_static, second_static,
                 d_sx, d_sy};
      f_ax   <= d_sx ? (~dx + AW'(1)) : dx;
      f_ay   <= d_sy ? (~dy + AW'(1)) : dy;
    end
  end

  // squaring chain
  cell_ctl_t     sq_ctl  [0:AW];
  logic [SA-1:0] sq_side [0:AW];
  logic [AW-1:0] sq_a0   [0:AW];
  logic [AW-1:0] sq_a1   [0:AW];
  logic [AW-1:0] sq_m0   [0:AW];
  logic [AW-1:0] sq_m1   [0:AW];
  logic [SQW-1:0] sq_acc0 [0:AW];
  logic [SQW-1:0] sq_acc1 [0:AW];

  assign sq_ctl[0]  = f_ctl;
  assign sq_side[0] = f_side;
  assign sq_a0[0]   = f_ax;
  assign sq_m0[0]   = f_ax;
  assign sq_a1[0]   = f_ay;
  assign sq_m1[0]   = f_ay;
  assign sq_acc0[0] = '0;
  assign sq_acc1[0] = '0;

  for (genvar i = 0; i < AW; i++) begin : g_sq
    dcr_mul_cell #(
      .AW(AW), .MW(AW), .PW(SQW), .SW(SA), .BIT(i)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_ctl(sq_ctl[i]), .in_side(sq_side[i]),
      .in_a0(sq_a0[i]), .in_a1(sq_a1[i]), .in_m0(sq_m0[i]), .in_m1(sq_m1[i]),
      .in_acc0(sq_acc0[i]), .in_acc1(sq_acc1[i]),
      .out_ctl(sq_ctl[i+1]), .out_side(sq_side[i+1]),
      .out_a0(sq_a0[i+1]), .out_a1(sq_a1[i+1]), .out_m0(sq_m0[i+1]), .out_m1(sq_m1[i+1]),
      .out_acc0(sq_acc0[i+1]), .out_acc1(sq_acc1[i+1])
    );
  end

  // sum of squares
  cell_ctl_t      s_ctl;
  logic [SB-1:0]  s_side;
  logic [SQW-1:0] s_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl <= '0;
    end else if (en) begin
      s_ctl <= sq_ctl[AW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side <= {sq_side[AW], sq_a0[AW], sq_a1[AW]};
      s_sum  <= sq_acc0[AW] + sq_acc1[AW];
    end
  end

  // root chain
  cell_ctl_t       rt_ctl  [0:RW];
  logic [SB-1:0]   rt_side [0:RW];
  logic [2*RW-1:0] rt_rem  [0:RW];
  logic [RW-1:0]   rt_root [0:RW];

  assign rt_ctl[0]  = s_ctl;
  assign rt_side[0] = s_side;
  assign rt_rem[0]  = s_sum;
  assign rt_root[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_rt
    dcr_sqrt_cell #(
      .RW(RW), .SW(SB), .BIT(RW - 1 - i)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_ctl(rt_ctl[i]), .in_side(rt_side[i]), .in_rem(rt_rem[i]), .in_root(rt_root[i]),
      .out_ctl(rt_ctl[i+1]), .out_side(rt_side[i+1]), .out_rem(rt_rem[i+1]),
      .out_root(rt_root[i+1])
    );
  end

  // length minus rest length
  logic [W-1:0]  r_x1, r_y1, r_x2, r_y2;
  logic          r_fs, r_ss, r_sx, r_sy;
  logic [AW-1:0] r_ax, r_ay;
  logic [RW-1:0] r_len;
  logic [W+1:0]  r_diff;
  logic          r_dsign;
  // rest length delayed to line up with the root chain output
  logic [W-2:0]  rest_length_q;

  assign {r_x1, r_y1, r_x2, r_y2, r_fs, r_ss, r_sx, r_sy, r_ax, r_ay} = rt_side[RW];
  assign r_len   = (rt_root[RW] == '0) ? RW'(TINY_LEN) : rt_root[RW];
  assign r_diff  = {1'b0, r_len} - {3'b000, rest_length_q};
  assign r_dsign = r_diff[W+1];

  cell_ctl_t     c_ctl;
  logic [SC-1:0] c_side;
  logic [AW-1:0] c_ax, c_ay;
  logic [W:0]    c_dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else if (en) begin
      c_ctl <= rt_ctl[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= {r_x1, r_y1, r_x2, r_y2, r_fs, r_ss, r_sx ^ r_dsign, r_sy ^ r_dsign, r_len};
      c_ax   <= r_ax;
      c_ay   <= r_ay;
      c_dmag <= r_dsign ? (~r_diff[W:0] + AW'(1)) : r_diff[W:0];
    end
  end

  // product chain
  cell_ctl_t      mu_ctl  [0:AW];
  logic [SC-1:0]  mu_side [0:AW];
  logic [AW-1:0]  mu_a0   [0:AW];
  logic [AW-1:0]  mu_a1   [0:AW];
  logic [AW-1:0]  mu_m0   [0:AW];
  logic [AW-1:0]  mu_m1   [0:AW];
  logic [SQW-1:0] mu_acc0 [0:AW];
  logic [SQW-1:0] mu_acc1 [0:AW];

  assign mu_ctl[0]  = c_ctl;
  assign mu_side[0] = c_side;
  assign mu_a0[0]   = c_ax;
  assign mu_a1[0]   = c_ay;
  assign mu_m0[0]   = c_dmag;
  assign mu_m1[0]   = c_dmag;
  assign mu_acc0[0] = '0;
  assign mu_acc1[0] = '0;

  for (genvar i = 0; i < AW; i++) begin : g_mu
    dcr_mul_cell #(
      .AW(AW), .MW(AW), .PW(SQW), .SW(SC), .BIT(i)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_ctl(mu_ctl[i]), .in_side(mu_side[i]),
      .in_a0(mu_a0[i]), .in_a1(mu_a1[i]), .in_m0(mu_m0[i]), .in_m1(mu_m1[i]),
      .in_acc0(mu_acc0[i]), .in_acc1(mu_acc1[i]),
      .out_ctl(mu_ctl[i+1]), .out_side(mu_side[i+1]),
      .out_a0(mu_a0[i+1]), .out_a1(mu_a1[i+1]), .out_m0(mu_m0[i+1]), .out_m1(mu_m1[i+1]),
      .out_acc0(mu_acc0[i+1]), .out_acc1(mu_acc1[i+1])
    );
  end

  // rounding numerators and divisor
  logic [SA-1:0] m_head;
  logic [RW-1:0] m_len;

  assign {m_head, m_len} = mu_side[AW];

  cell_ctl_t      n_ctl;
  logic [SA-1:0]  n_side;
  logic [DNW-1:0] n_d;
  logic [NW-1:0]  n_num0, n_num1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_ctl <= '0;
    end else if (en) begin
      n_ctl <= mu_ctl[AW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_side <= m_head;
      n_d    <= DNW'(m_len) << 2;
      n_num0 <= (NW'(mu_acc0[AW]) << 1) + (NW'(m_len) << 1);
      n_num1 <= (NW'(mu_acc1[AW]) << 1) + (NW'(m_len) << 1);
    end
  end

  // quotient chain
  cell_ctl_t      dv_ctl  [0:QW];
  logic [SA-1:0]  dv_side [0:QW];
  logic [DNW-1:0] dv_d    [0:QW];
  logic [NW-1:0]  dv_rem0 [0:QW];
  logic [NW-1:0]  dv_rem1 [0:QW];
  logic [QW-1:0]  dv_q0   [0:QW];
  logic [QW-1:0]  dv_q1   [0:QW];

  assign dv_ctl[0]  = n_ctl;
  assign dv_side[0] = n_side;
  assign dv_d[0]    = n_d;
  assign dv_rem0[0] = n_num0;
  assign dv_rem1[0] = n_num1;
  assign dv_q0[0]   = '0;
  assign dv_q1[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_dv
    dcr_div_cell #(
      .NW(NW), .DW(DNW), .QW(QW), .SW(SA), .BIT(QW - 1 - i)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_ctl(dv_ctl[i]), .in_side(dv_side[i]), .in_d(dv_d[i]),
      .in_rem0(dv_rem0[i]), .in_rem1(dv_rem1[i]), .in_q0(dv_q0[i]), .in_q1(dv_q1[i]),
      .out_ctl(dv_ctl[i+1]), .out_side(dv_side[i+1]), .out_d(dv_d[i+1]),
      .out_rem0(dv_rem0[i+1]), .out_rem1(dv_rem1[i+1]),
      .out_q0(dv_q0[i+1]), .out_q1(dv_q1[i+1])
    );
  end

  // apply correction with saturation
  function automatic logic [W-1:0] sat(input logic [W+2:0] v);
    logic [W-1:0] res;
    if ((v[W+2:W-1] == '0) || (v[W+2:W-1] == '1)) begin
      res = v[W-1:0];
    end else if (v[W+2]) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = {1'b0, {(W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [W-1:0] o_x1, o_y1, o_x2, o_y2;
  logic         o_fs, o_ss, o_nx, o_ny;
  logic [W+2:0] cx, cy;
  logic [RES-1:0] push_data;
  logic           push;

  assign {o_x1, o_y1, o_x2, o_y2, o_fs, o_ss, o_nx, o_ny} = dv_side[QW];
  assign cx = o_nx ? (~{2'b00, dv_q0[QW]} + (W+3)'(1)) : {2'b00, dv_q0[QW]};
  assign cy = o_ny ? (~{2'b00, dv_q1[QW]} + (W+3)'(1)) : {2'b00, dv_q1[QW]};

  assign push_data = {
    o_fs ? o_x1 : sat({{3{o_x1[W-1]}}, o_x1} + cx),
    o_fs ? o_y1 : sat({{3{o_y1[W-1]}}, o_y1} + cy),
    o_ss ? o_x2 : sat({{3{o_x2[W-1]}}, o_x2} - cx),
    o_ss ? o_y2 : sat({{3{o_y2[W-1]}}, o_y2} - cy)
  };
  assign push = dv_ctl[QW].valid && en;

  // rest length pipeline alongside the front stage, the squaring chain and sum stage
  logic [W-2:0] rl_pipe [0:AW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rl_pipe[0] <= rest_length;
    end
  end

  for (genvar i = 0; i < AW + 1; i++) begin : g_rl
    always_ff @(posedge clk) begin
      if (en) begin
        rl_pipe[i+1] <= rl_pipe[i];
      end
    end
  end

  // the root chain carries the rest length as well
  logic [W-2:0] rl_rt [0:RW];

  assign rl_rt[0] = rl_pipe[AW+1];

  for (genvar i = 0; i < RW; i++) begin : g_rlr
    always_ff @(posedge clk) begin
      if (en) begin
        rl_rt[i+1] <= rl_rt[i];
      end
    end
  end

  assign rest_length_q = rl_rt[RW];

  // output register with skid
  logic [RES-1:0] out_data;
  logic [RES-1:0] skid_data;
  logic           pop;

  assign pop = out_valid && out_ready;
  assign {new_first_x, new_first_y, new_second_x, new_second_y} = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  `DCR_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid)
  `DCR_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, f_ctl.valid)
  `DCR_ASSERT_NEXT(a_push_lands, push, out_valid)
  `DCR_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid && out_valid)

endmodule
`default_nettype wire

/* tb/sv/distance_constraint_relax_top_tb.sv */
`timescale 1ns / 1ps
module distance_constraint_relax_top_tb;

  localparam int CW = 32;
  localparam int LATENCY = 4 * CW + 9;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CW-1:0] MAX_POS = 32'h7fffffff;
  localparam logic [CW-1:0] MIN_NEG = 32'h80000000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [CW-1:0] p1x, p1y, p2x, p2y;
  } points_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic [CW-2:0] rest_length = '0;
  logic first_static = 1'b0, second_static = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CW-1:0] new_first_x, new_first_y, new_second_x, new_second_y;

  points_t moved_q[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  bit busy_sender = 1'b0;
  bit busy_receiver = 1'b0;

  distance_constraint_relax_top #(.COORD_WIDTH(CW)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic wide_t sext(logic [CW-1:0] v);
    return wide_t'($signed({{(128-CW){v[CW-1]}}, v}));
  endfunction

  function automatic logic [127:0] int_sqrt(logic [127:0] s);
    logic [127:0] root, cand;
    root = '0;
    for (int k = 47; k >= 0; k--) begin
      cand = root | (128'd1 << k);
      if (cand * cand <= s) root = cand;
    end
    return root;
  endfunction

  // rounded d * diff / den, ties away from zero
  function automatic wide_t scaled_share(wide_t d, wide_t diff, wide_t den);
    logic [127:0] ad, adiff, num, q;
    ad = d < 0 ? -d : d;
    adiff = diff < 0 ? -diff : diff;
    num = ad * adiff;
    q = (2 * num + den) / (2 * den);
    return ((d < 0) != (diff < 0)) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic logic [CW-1:0] clamp(wide_t v);
    if (v > 128'sd2147483647) return MAX_POS;
    if (v < -128'sd2147483648) return MIN_NEG;
    return v[CW-1:0];
  endfunction

  function automatic points_t relax(logic [CW-1:0] x1, y1, x2, y2, logic [CW-2:0] rest,
                                    logic s1, s2);
    wide_t dx, dy, len, diff, cx, cy;
    logic [127:0] ax, ay;
    points_t r;
    dx = sext(x2) - sext(x1);
    dy = sext(y2) - sext(y1);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    len = wide_t'(int_sqrt(ax * ax + ay * ay));
    if (len == 0) len = 7;
    diff = len - wide_t'({97'd0, rest});
    cx = scaled_share(dx, diff, 2 * len);
    cy = scaled_share(dy, diff, 2 * len);
    r.p1x = s1 ? x1 : clamp(sext(x1) + cx);
    r.p1y = s1 ? y1 : clamp(sext(y1) + cy);
    r.p2x = s2 ? x2 : clamp(sext(x2) - cx);
    r.p2y = s2 ? y2 : clamp(sext(y2) - cy);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(logic [CW-1:0] x1, y1, x2, y2, logic [CW-2:0] rest, logic s1, s2,
                           bit idle);
    int gap;
    first_x = x1;
    first_y = y1;
    second_x = x2;
    second_y = y2;
    rest_length = rest;
    first_static = s1;
    second_static = s2;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    moved_q.push_back(relax(x1, y1, x2, y2, rest, s1, s2));
    @(negedge clk);
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (moved_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (!busy_receiver) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 99) < 70) ? 1'b1 :
                  ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
      if (!out_ready && $urandom_range(0, 19) == 0) hold_left = $urandom_range(5, 30);
    end
  end

  always @(posedge clk) begin
    points_t e;
    logic [CW-1:0] got[4];
    logic [CW-1:0] want[4];
    if (!rst && out_valid && out_ready) begin
      if (moved_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = moved_q.pop_front();
        got = '{new_first_x, new_first_y, new_second_x, new_second_y};
        want = '{e.p1x, e.p1y, e.p2x, e.p2y};
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h got %h", i, want[i], got[i]);
          end
        end
      end
    end
  end

  task automatic test_extremes();
    send_beat('0, '0, '0, '0, '0, 0, 0, 0);
    send_beat(32'h00010000, 32'h00020000, 32'h00010000, 32'h00020000, 31'h00010000, 0, 0, 0);
    send_beat(MIN_NEG, MIN_NEG, MAX_POS, MAX_POS, '0, 0, 0, 0);
    send_beat(MAX_POS, MAX_POS, MIN_NEG, MIN_NEG, '0, 0, 0, 0);
    send_beat(MIN_NEG, MAX_POS, MAX_POS, MIN_NEG, 31'h7fffffff, 0, 0, 0);
    send_beat(MAX_POS, '0, MIN_NEG, '0, 31'h7fffffff, 0, 0, 0);
    send_beat('0, '0, 32'h00030000, 32'h00040000, 31'h00050000, 0, 0, 0);
    send_beat('0, '0, 32'h00030000, 32'h00040000, 31'h000a0000, 0, 0, 0);
    send_beat('0, '0, 32'h00000001, '0, '0, 0, 0, 0);
    send_beat('0, '0, 32'h00000003, '0, '0, 0, 0, 0);
    send_beat(32'hffffffff, 32'hffffffff, '0, '0, 31'h7fffffff, 0, 0, 0);
    drain();
  endtask

  task automatic test_static_flags();
    for (int s = 0; s < 4; s++) begin
      send_beat(32'h00100000, 32'hfff00000, 32'hff000000, 32'h01000000, 31'h00080000,
                s[0], s[1], 0);
      send_beat(MIN_NEG, MIN_NEG, MAX_POS, MAX_POS, 31'h7fffffff, s[0], s[1], 0);
      send_beat(32'h12345678, 32'h12345678, 32'h12345678, 32'h12345678, 31'h1, s[0], s[1], 0);
    end
    drain();
  endtask

  task automatic send_random(int count);
    logic [CW-1:0] x1, y1, x2, y2;
    logic [CW-2:0] rest;
    int mode;
    bit idle;
    idle = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) idle = $urandom_range(0, 3) != 0;
      mode = $urandom_range(0, 9);
      x1 = $urandom();
      y1 = $urandom();
      if (mode < 4) begin
        x2 = x1 + CW'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
        y2 = y1 + CW'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
      end else if (mode < 5) begin
        x2 = x1 + CW'($signed($urandom_range(0, 6)) - 3);
        y2 = y1 + CW'($signed($urandom_range(0, 6)) - 3);
      end else if (mode < 6) begin
        x2 = x1;
        y2 = y1;
      end else if (mode < 7) begin
        x1 = $urandom_range(0, 1) ? MAX_POS - $urandom_range(0, 255) :
                                    MIN_NEG + $urandom_range(0, 255);
        x2 = $urandom();
        y2 = $urandom();
      end else begin
        x2 = $urandom();
        y2 = $urandom();
      end
      rest = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h00200000));
      send_beat(x1, y1, x2, y2, rest, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                idle);
    end
  endtask

  task automatic test_random_stream();
    busy_receiver = 1'b1;
    send_random(460);
  endtask

  task automatic test_backpressure();
    hold_left = 2000;
    send_random(200);
    in_valid = 1'b0;
    drain();
    send_random(20);
    in_valid = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_static_flags();
    test_random_stream();
    test_backpressure();
    in_valid = 1'b0;
    drain();
    repeat (LATENCY + 20) @(negedge clk);
    if (mismatches == 0 && moved_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/dcr_pkg.sv
hdl/dcr_mul_cell.sv
hdl/dcr_sqrt_cell.sv
hdl/dcr_div_cell.sv
hdl/distance_constraint_relax_top.sv
tb/sv/distance_constraint_relax_top_tb.sv
